>>> hdl/first_fit_segment_allocator_macros.svh
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FFSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffsa check failed");

// next-cycle implication
`define FFSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffsa check failed");

`endif

>>> hdl/ffsa_pkg.sv
package ffsa_pkg;

    localparam int BLK_W = 16;
    localparam int ID_W  = 16;
    localparam int ST_W  = 3;

    localparam logic [BLK_W-1:0] RESET_TOTAL = 16'd1024;

    localparam logic FUNC_RESERVE = 1'b0;
    localparam logic FUNC_FREE    = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_ZERO_SIZE = 3'd1,
        ST_ID_USED   = 3'd2,
        ST_NO_FIT    = 3'd3,
        ST_NO_ENTRY  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_WR_REST,
        S_WR_SEG,
        S_DONE
    } fsm_state_t;

    typedef struct packed {
        logic             used;
        logic [ID_W-1:0]  owner;
        logic [BLK_W-1:0] size;
    } seg_entry_t;

endpackage

>>> hdl/ffsa_req_if.sv
interface ffsa_req_if;
    import ffsa_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [BLK_W-1:0] request_size;
    logic [ID_W-1:0]  owner_id;

    modport source (output valid, func, request_size, owner_id, input ready);
    modport sink   (input valid, func, request_size, owner_id, output ready);
endinterface

>>> hdl/ffsa_rsp_if.sv
interface ffsa_rsp_if;
    import ffsa_pkg::*;

    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [BLK_W-1:0] start_block;
    logic [BLK_W-1:0] free_total;

    modport source (output valid, status, start_block, free_total, input ready);
    modport sink   (input valid, status, start_block, free_total, output ready);
endinterface

>>> hdl/ffsa_ram.sv
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hdl/first_fit_segment_allocator.sv
// First-fit segment allocator. The segment table (size, owner, used flag per
// entry) lives in one RAM with one write and one registered read port. Each
// request makes a full scan over the current segment count, then, for a
// successful request, a shift of the entries behind the segment when it is
// split or merged, a write of the rest segment when it is split, and a write
// of the segment itself. One request is handled at a time; a finished result
// waits in the output register while the next request is taken. After reset
// and after every write of total_blocks the table is reinitialised, during
// which no request is taken.
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ffsa_req_if.sink                    req,
    ffsa_rsp_if.source                  rsp,
    input  logic                        cfg_we,
    input  logic [ffsa_pkg::BLK_W-1:0]  cfg_wdata
);
    import ffsa_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int EW = $bits(seg_entry_t);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);
    localparam logic [CW-1:0] ONE_CNT = CW'(1);

    typedef struct packed {
        logic [CW-1:0]    rd_idx;
        logic             pend;
        logic [CW-1:0]    pos;
        logic [BLK_W-1:0] sum;
        logic             dup;
        logic             found;
        logic [IW-1:0]    hit;
        logic [BLK_W-1:0] hit_size;
        logic [BLK_W-1:0] hit_start;
        logic             prev_used;
        logic [BLK_W-1:0] prev_size;
        logic             has_next;
        logic             next_used;
        logic [BLK_W-1:0] next_size;
    } scan_t;

    typedef struct packed {
        logic          up;
        logic [CW-1:0] src;
        logic [CW-1:0] left;
        logic          pend;
        logic [IW-1:0] dst;
        logic [1:0]    gap;
    } shift_t;

    fsm_state_t       state_reg, state_next;
    logic [BLK_W-1:0] total_reg, total_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [BLK_W-1:0] free_reg, free_next;
    logic             func_reg, func_next;
    logic [BLK_W-1:0] size_reg, size_next;
    logic [ID_W-1:0]  id_reg, id_next;
    scan_t            scan_reg, scan_next;
    shift_t           sh_reg, sh_next;
    status_t          status_reg, status_next;
    logic             need_rest_reg, need_rest_next;
    logic [BLK_W-1:0] rest_reg, rest_next;
    logic [IW-1:0]    wr_idx_reg, wr_idx_next;
    logic [BLK_W-1:0] wr_size_reg, wr_size_next;
    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    logic [BLK_W-1:0] out_start_reg, out_start_next;
    logic [BLK_W-1:0] out_free_reg, out_free_next;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    seg_entry_t       ram_wentry;
    logic [IW-1:0]    ram_raddr;
    logic [EW-1:0]    ram_rdata;
    seg_entry_t       rd_entry;
    logic             id_match;
    logic             fits;
    logic             merge_prev;
    logic             merge_next;
    logic [1:0]       gap;
    logic [BLK_W-1:0] rest;
    logic [BLK_W-1:0] merged;
    logic [CW-1:0]    tail_src;

    ffsa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry   = seg_entry_t'(ram_rdata);
    assign id_match   = rd_entry.used && (rd_entry.owner == id_reg);
    assign fits       = !rd_entry.used && (rd_entry.size >= size_reg);
    assign merge_prev = (scan_reg.hit != '0) && !scan_reg.prev_used;
    assign merge_next = scan_reg.has_next && !scan_reg.next_used;
    assign gap        = {1'b0, merge_prev} + {1'b0, merge_next};
    assign rest       = scan_reg.hit_size - size_reg;
    assign merged     = scan_reg.hit_size
                      + (merge_prev ? scan_reg.prev_size : '0)
                      + (merge_next ? scan_reg.next_size : '0);
    assign tail_src   = CW'(scan_reg.hit) + ONE_CNT + CW'(merge_next);

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.start_block = out_start_reg;
    assign rsp.free_total  = out_free_reg;

    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        count_next      = count_reg;
        free_next       = free_reg;
        func_next       = func_reg;
        size_next       = size_reg;
        id_next         = id_reg;
        scan_next       = scan_reg;
        sh_next         = sh_reg;
        status_next     = status_reg;
        need_rest_next  = need_rest_reg;
        rest_next       = rest_reg;
        wr_idx_next     = wr_idx_reg;
        wr_size_next    = wr_size_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_free_next   = out_free_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wentry      = '0;
        ram_raddr       = '0;

        unique case (state_reg)
            S_INIT:
            begin
                ram_we          = 1'b1;
                ram_wentry.size = total_reg;
                count_next      = ONE_CNT;
                free_next       = total_reg;
                state_next      = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = req.func;
                    size_next  = req.request_size;
                    id_next    = req.owner_id;
                    scan_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_reg.rd_idx < count_reg)
                begin
                    ram_raddr        = scan_reg.rd_idx[IW-1:0];
                    scan_next.rd_idx = scan_reg.rd_idx + ONE_CNT;
                    scan_next.pend   = 1'b1;
                end
                else
                begin
                    scan_next.pend = 1'b0;
                end
                if (scan_reg.pend)
                begin
                    scan_next.pos = scan_reg.pos + ONE_CNT;
                    scan_next.sum = scan_reg.sum + rd_entry.size;
                    if (id_match)
                    begin
                        scan_next.dup = 1'b1;
                    end
                    if (!scan_reg.found)
                    begin
                        if ((func_reg == FUNC_FREE) ? id_match : fits)
                        begin
                            scan_next.found     = 1'b1;
                            scan_next.hit       = scan_reg.pos[IW-1:0];
                            scan_next.hit_size  = rd_entry.size;
                            scan_next.hit_start = scan_reg.sum;
                        end
                        else
                        begin
                            scan_next.prev_used = rd_entry.used;
                            scan_next.prev_size = rd_entry.size;
                        end
                    end
                    else if (scan_reg.pos == CW'(scan_reg.hit) + ONE_CNT)
                    begin
                        scan_next.has_next  = 1'b1;
                        scan_next.next_used = rd_entry.used;
                        scan_next.next_size = rd_entry.size;
                    end
                end
                if ((scan_reg.rd_idx >= count_reg) && !scan_reg.pend)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                sh_next        = '0;
                need_rest_next = 1'b0;
                rest_next      = rest;
                state_next     = S_DONE;
                if (func_reg == FUNC_RESERVE)
                begin
                    priority if (size_reg == '0)
                    begin
                        status_next = ST_ZERO_SIZE;
                    end
                    else if (scan_reg.dup)
                    begin
                        status_next = ST_ID_USED;
                    end
                    else if (!scan_reg.found)
                    begin
                        status_next = ST_NO_FIT;
                    end
                    else if ((rest != '0) && (count_reg >= MAX_CNT))
                    begin
                        status_next = ST_NO_ENTRY;
                    end
                    else
                    begin
                        status_next  = ST_OK;
                        free_next    = free_reg - size_reg;
                        wr_idx_next  = scan_reg.hit;
                        wr_size_next = size_reg;
                        state_next   = S_SHIFT;
                        if (rest != '0)
                        begin
                            need_rest_next = 1'b1;
                            count_next     = count_reg + ONE_CNT;
                            sh_next.up     = 1'b1;
                            sh_next.src    = count_reg - ONE_CNT;
                            sh_next.left   = count_reg - ONE_CNT - CW'(scan_reg.hit);
                            sh_next.gap    = 2'd1;
                        end
                    end
                end
                else
                begin
                    if (!scan_reg.found)
                    begin
                        status_next = ST_NO_ENTRY;
                    end
                    else
                    begin
                        status_next  = ST_OK;
                        free_next    = free_reg + scan_reg.hit_size;
                        count_next   = count_reg - CW'(gap);
                        wr_idx_next  = scan_reg.hit - IW'(merge_prev);
                        wr_size_next = merged;
                        sh_next.src  = tail_src;
                        sh_next.left = (gap == 2'd0) ? '0 : count_reg - tail_src;
                        sh_next.gap  = gap;
                        state_next   = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                if (sh_reg.left != '0)
                begin
                    ram_raddr    = sh_reg.src[IW-1:0];
                    sh_next.src  = sh_reg.up ? sh_reg.src - ONE_CNT : sh_reg.src + ONE_CNT;
                    sh_next.left = sh_reg.left - ONE_CNT;
                    sh_next.pend = 1'b1;
                    sh_next.dst  = sh_reg.up ? IW'(sh_reg.src + ONE_CNT)
                                             : IW'(sh_reg.src - CW'(sh_reg.gap));
                end
                else
                begin
                    sh_next.pend = 1'b0;
                end
                if (sh_reg.pend)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = sh_reg.dst;
                    ram_wentry = rd_entry;
                end
                if ((sh_reg.left == '0) && !sh_reg.pend)
                begin
                    state_next = need_rest_reg ? S_WR_REST : S_WR_SEG;
                end
            end
            S_WR_REST:
            begin
                ram_we          = 1'b1;
                ram_waddr       = wr_idx_reg + IW'(1);
                ram_wentry.size = rest_reg;
                state_next      = S_WR_SEG;
            end
            S_WR_SEG:
            begin
                ram_we          = 1'b1;
                ram_waddr       = wr_idx_reg;
                ram_wentry.size = wr_size_reg;
                if (func_reg == FUNC_RESERVE)
                begin
                    ram_wentry.used  = 1'b1;
                    ram_wentry.owner = id_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_start_next  = (status_reg == ST_OK) ? scan_reg.hit_start : '0;
                    out_free_next   = free_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        if (cfg_we)
        begin
            total_next = cfg_wdata;
            state_next = S_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            total_reg     <= RESET_TOTAL;
            count_reg     <= ONE_CNT;
            free_reg      <= RESET_TOTAL;
            scan_reg      <= '0;
            sh_reg        <= '0;
            status_reg    <= ST_OK;
            need_rest_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            scan_reg      <= scan_next;
            sh_reg        <= sh_next;
            status_reg    <= status_next;
            need_rest_reg <= need_rest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        size_reg       <= size_next;
        id_reg         <= id_next;
        rest_reg       <= rest_next;
        wr_idx_reg     <= wr_idx_next;
        wr_size_reg    <= wr_size_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_free_reg   <= out_free_next;
    end
endmodule

>>> hdl/ffsa_checker.sv
`include "first_fit_segment_allocator_macros.svh"

module ffsa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [ffsa_pkg::ST_W-1:0]   rsp_status,
    input logic [ffsa_pkg::BLK_W-1:0]  rsp_start_block,
    input logic                        cfg_we
);
    import ffsa_pkg::*;

    // a waiting result holds
    `FFSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_start_block))

    // failed requests report block zero
    `FFSA_ASSERT_NOW(a_err_start, rsp_valid && (rsp_status != ST_OK), rsp_start_block == '0)

    // one request in flight: ready drops after a transfer
    `FFSA_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

    // table rebuild after a pool size write blocks requests
    `FFSA_ASSERT_NEXT(a_cfg_init, cfg_we, !req_ready)
endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_start_block (rsp.start_block),
    .cfg_we          (cfg_we)
);

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ffsa_pkg::*;

    localparam int MAX_SEG     = 64;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 2 * MAX_SEG + 20;

    typedef struct packed {
        logic             func;
        logic [BLK_W-1:0] size;
        logic [ID_W-1:0]  id;
        logic             has_exp;
        status_t          status;
        logic [BLK_W-1:0] start;
        logic [BLK_W-1:0] free_total;
    } stim_row_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [BLK_W-1:0] start;
        logic [BLK_W-1:0] free_total;
    } alloc_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [BLK_W-1:0] cfg_wdata;

    ffsa_req_if req ();
    ffsa_rsp_if rsp ();

    first_fit_segment_allocator #(.MAX_SEGMENTS(MAX_SEG)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // model state
    logic [BLK_W-1:0] pool_blocks;
    logic [BLK_W-1:0] seg_size [MAX_SEG];
    logic [ID_W-1:0]  seg_owner [MAX_SEG];
    logic             seg_used [MAX_SEG];
    int               seg_count;

    alloc_result_t result_queue[$];
    stim_row_t     directed[$];
    int  errors;
    int  idle_cycles;
    int  send_gap;
    int  recv_stall;
    logic [ID_W-1:0] live_ids[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void table_reset(input logic [BLK_W-1:0] blocks);
        pool_blocks = blocks;
        for (int i = 0; i < MAX_SEG; i++)
        begin
            seg_size[i]  = '0;
            seg_owner[i] = '0;
            seg_used[i]  = 1'b0;
        end
        seg_size[0] = blocks;
        seg_count   = 1;
        live_ids.delete();
    endfunction

    function automatic logic [BLK_W-1:0] free_blocks();
        logic [BLK_W-1:0] s;
        s = '0;
        for (int i = 0; i < seg_count; i++)
            if (!seg_used[i])
                s += seg_size[i];
        return s;
    endfunction

    function automatic logic [BLK_W-1:0] seg_base(input int idx);
        logic [BLK_W-1:0] s;
        s = '0;
        for (int i = 0; i < idx; i++)
            s += seg_size[i];
        return s;
    endfunction

    function automatic void drop_seg(input int idx);
        for (int i = idx; i < seg_count - 1; i++)
        begin
            seg_size[i]  = seg_size[i+1];
            seg_owner[i] = seg_owner[i+1];
            seg_used[i]  = seg_used[i+1];
        end
        seg_count--;
        seg_size[seg_count]  = '0;
        seg_owner[seg_count] = '0;
        seg_used[seg_count]  = 1'b0;
    endfunction

    function automatic void forget_id(input logic [ID_W-1:0] id);
        for (int k = 0; k < live_ids.size(); k++)
            if (live_ids[k] == id)
            begin
                live_ids.delete(k);
                return;
            end
    endfunction

    function automatic alloc_result_t allocate(input logic func,
                                               input logic [BLK_W-1:0] size,
                                               input logic [ID_W-1:0] id);
        alloc_result_t r;
        logic [BLK_W-1:0] rest;
        int hit;
        r.status = ST_NO_FIT;
        r.start  = '0;
        hit = -1;
        for (int i = 0; i < seg_count; i++)
            if (hit < 0 && seg_used[i] && seg_owner[i] == id)
                hit = i;
        if (func == FUNC_RESERVE)
        begin
            if (size == 0)
                r.status = ST_ZERO_SIZE;
            else if (hit >= 0)
                r.status = ST_ID_USED;
            else
            begin
                for (int i = 0; i < seg_count; i++)
                begin
                    if (hit < 0 && !seg_used[i] && seg_size[i] >= size)
                    begin
                        hit  = i;
                        rest = seg_size[i] - size;
                        if (rest != 0 && seg_count >= MAX_SEG)
                            r.status = ST_NO_ENTRY;
                        else
                        begin
                            if (rest != 0)
                            begin
                                for (int j = seg_count; j > i + 1; j--)
                                begin
                                    seg_size[j]  = seg_size[j-1];
                                    seg_owner[j] = seg_owner[j-1];
                                    seg_used[j]  = seg_used[j-1];
                                end
                                seg_size[i+1]  = rest;
                                seg_owner[i+1] = '0;
                                seg_used[i+1]  = 1'b0;
                                seg_count++;
                                seg_size[i] = size;
                            end
                            seg_used[i]  = 1'b1;
                            seg_owner[i] = id;
                            r.status = ST_OK;
                            r.start  = seg_base(i);
                            live_ids = {live_ids, id};
                        end
                    end
                end
            end
        end
        else if (hit < 0)
            r.status = ST_NO_ENTRY;
        else
        begin
            r.status = ST_OK;
            r.start  = seg_base(hit);
            seg_used[hit]  = 1'b0;
            seg_owner[hit] = '0;
            forget_id(id);
            if (hit + 1 < seg_count && !seg_used[hit+1])
            begin
                seg_size[hit] = seg_size[hit] + seg_size[hit+1];
                drop_seg(hit + 1);
            end
            if (hit > 0 && !seg_used[hit-1])
            begin
                seg_size[hit-1] = seg_size[hit-1] + seg_size[hit];
                drop_seg(hit);
            end
        end
        r.free_total = free_blocks();
        return r;
    endfunction

    task automatic send(input logic func, input logic [BLK_W-1:0] size,
                        input logic [ID_W-1:0] id);
        while ($urandom_range(99) < send_gap)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.func         <= func;
        req.request_size <= size;
        req.owner_id     <= id;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        result_queue = {result_queue, allocate(func, size, id)};
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (result_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_pool(input logic [BLK_W-1:0] blocks);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= blocks;
        @(posedge clk);
        cfg_we <= 1'b0;
        table_reset(blocks);
        @(posedge clk);
    endtask

    function automatic stim_row_t row(input logic func, input int size, input int id,
                                      input logic has_exp, input status_t st,
                                      input int start, input int ftot);
        stim_row_t r;
        r.func = func;
        r.size = size[BLK_W-1:0];
        r.id = id[ID_W-1:0];
        r.has_exp = has_exp;
        r.status = st;
        r.start = start[BLK_W-1:0];
        r.free_total = ftot[BLK_W-1:0];
        return r;
    endfunction

    // result side: stall, check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rsp.ready <= ($urandom_range(99) >= recv_stall);
            if (rsp.valid && rsp.ready)
            begin
                if (result_queue.size() == 0)
                begin
                    $display("%0t: unexpected transfer st=%0d start=%0d free=%0d",
                             $time, rsp.status, rsp.start_block, rsp.free_total);
                    errors++;
                end
                else
                begin
                    alloc_result_t e;
                    e = result_queue.pop_front();
                    if (rsp.status !== e.status)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, e.status, rsp.status);
                        errors++;
                    end
                    if (rsp.start_block !== e.start)
                    begin
                        $display("%0t: start_block exp %0d got %0d", $time, e.start,
                                 rsp.start_block);
                        errors++;
                    end
                    if (rsp.free_total !== e.free_total)
                    begin
                        $display("%0t: free_total exp %0d got %0d", $time, e.free_total,
                                 rsp.free_total);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic random_phase(input int count, input int max_size,
                                input int id_span);
        int op;
        logic [ID_W-1:0] id;
        for (int n = 0; n < count; n++)
        begin
            op = $urandom_range(99);
            if (op < 45)
            begin
                id = ID_W'($urandom_range(id_span));
                if ($urandom_range(15) == 0)
                    id = ID_W'($urandom);
                send(FUNC_RESERVE, BLK_W'($urandom_range(max_size, 1)), id);
            end
            else if (op < 85 && live_ids.size() != 0)
                send(FUNC_FREE, BLK_W'($urandom),
                     live_ids[$urandom_range(live_ids.size() - 1)]);
            else if (op < 90)
                send(FUNC_RESERVE, '0, ID_W'($urandom));
            else if (op < 95)
                send(FUNC_RESERVE, BLK_W'($urandom), ID_W'($urandom));
            else
                send(FUNC_FREE, BLK_W'($urandom), ID_W'($urandom));
        end
    endtask

    initial
    begin
        alloc_result_t got;
        clk = 1'b0;
        errors = 0;
        send_gap = 0;
        recv_stall = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.func = FUNC_RESERVE;
        req.request_size = '0;
        req.owner_id = '0;
        rsp.ready = 1'b0;
        table_reset(RESET_TOTAL);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = {directed, row(FUNC_RESERVE, 0, 5, 1, ST_ZERO_SIZE, 0, 1024)};
        directed = {directed, row(FUNC_FREE, 0, 5, 1, ST_NO_ENTRY, 0, 1024)};
        directed = {directed, row(FUNC_RESERVE, 1025, 5, 1, ST_NO_FIT, 0, 1024)};
        directed = {directed, row(FUNC_RESERVE, 100, 16'hffff, 1, ST_OK, 0, 924)};
        directed = {directed, row(FUNC_RESERVE, 7, 16'hffff, 1, ST_ID_USED, 0, 924)};
        directed = {directed, row(FUNC_RESERVE, 200, 0, 1, ST_OK, 100, 724)};
        directed = {directed, row(FUNC_RESERVE, 724, 3, 1, ST_OK, 300, 0)};
        directed = {directed, row(FUNC_RESERVE, 1, 9, 1, ST_NO_FIT, 0, 0)};
        directed = {directed, row(FUNC_FREE, 16'hffff, 0, 1, ST_OK, 100, 200)};
        directed = {directed, row(FUNC_FREE, 0, 16'hffff, 0, ST_OK, 0, 0)};
        directed = {directed, row(FUNC_FREE, 0, 3, 0, ST_OK, 0, 0)};
        directed = {directed, row(FUNC_RESERVE, 16'hffff, 16'haaaa, 1, ST_NO_FIT, 0, 1024)};
        directed = {directed, row(FUNC_RESERVE, 1024, 16'h5555, 1, ST_OK, 0, 0)};
        directed = {directed, row(FUNC_FREE, 0, 16'h5555, 1, ST_OK, 0, 1024)};
        foreach (directed[k])
        begin
            send(directed[k].func, directed[k].size, directed[k].id);
            if (directed[k].has_exp)
            begin
                got.status = directed[k].status;
                got.start = directed[k].start;
                got.free_total = directed[k].free_total;
                result_queue[result_queue.size() - 1] = got;
            end
        end

        // empty pool and one-block pool
        write_pool(16'd0);
        send(FUNC_RESERVE, 16'd1, 16'd1);
        send(FUNC_RESERVE, 16'hffff, 16'd2);
        write_pool(16'd1);
        send(FUNC_RESERVE, 16'd1, 16'd1);
        send(FUNC_FREE, 16'd0, 16'd1);
        // fill the table with single blocks
        write_pool(16'd200);
        for (int k = 0; k < MAX_SEG + 2; k++)
            send(FUNC_RESERVE, 16'd1, ID_W'(k));
        send(FUNC_FREE, 16'd0, 16'd0);
        send(FUNC_FREE, 16'd0, 16'd2);
        send(FUNC_FREE, 16'd0, 16'd1);
        write_pool(16'hffff);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_gap = 0;  recv_stall = 0;  end
                1: begin send_gap = 51; recv_stall = 0;  end
                2: begin send_gap = 0;  recv_stall = 51; end
                default: begin send_gap = 19; recv_stall = 19; end
            endcase
            if (ph == 4)
                write_pool(16'd300);
            if (ph == 6)
                write_pool(16'd1024);
            random_phase(200, (ph == 2 || ph == 7) ? 16'hffff :
                         (ph >= 4 ? 12 : 2000), ph >= 4 ? 80 : 40);
        end

        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
